[hdl/wsc_pkg.sv]
// Shared types, constants and the arctangent table for the waypoint steering core.
`timescale 1ns / 1ps
`default_nettype none
package wsc_pkg;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 16;
  localparam int REACH_W  = 31;
  localparam int STEP_W   = 15;
  localparam int LIMIT_W  = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Parameter defaults
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // CORDIC datapath width: covers magnitude 2^31 times gain and sqrt(2)
  localparam int XW = 35;

  // Front/back queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REACH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  typedef struct packed {
    logic [REACH_W-1:0] reach_distance;
    logic [STEP_W-1:0]  max_steer_step;
    logic [LIMIT_W-1:0] steer_limit;
  } cfg_t;

  // One classified tick handed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [ANGLE_W-1:0] heading;
    logic                      adv;
    logic                      fin;
  } qent_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hdl/wsc_ifs.sv]
// Valid/ready channel interfaces for input ticks, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface wsc_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [wsc_pkg::COORD_W-1:0]         vehicle_x;
  logic signed [wsc_pkg::COORD_W-1:0]         vehicle_y;
  logic signed [wsc_pkg::ANGLE_W-1:0]         vehicle_heading;
  logic signed [wsc_pkg::COORD_W-1:0]         target_x;
  logic signed [wsc_pkg::COORD_W-1:0]         target_y;
  logic signed [wsc_pkg::COORD_W-1:0]         next_x;
  logic signed [wsc_pkg::COORD_W-1:0]         next_y;
  logic                                       next_exists;

  modport source (output valid, vehicle_x, vehicle_y, vehicle_heading, target_x, target_y,
                  next_x, next_y, next_exists, input ready);
  modport sink   (input valid, vehicle_x, vehicle_y, vehicle_heading, target_x, target_y,
                  next_x, next_y, next_exists, output ready);
endinterface

interface wsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wsc_pkg::ANGLE_W-1:0] steer_angle;
  logic                               advanced;
  logic                               finished;

  modport source (output valid, steer_angle, advanced, finished, input ready);
  modport sink   (input valid, steer_angle, advanced, finished, output ready);
endinterface

interface wsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wsc_pkg::CFG_IDX_W-1:0]     index;
  logic [wsc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/waypoint_steering_control_core.sv]
// Top level: configuration registers, front end, queue and back end of the steering core.
// The front end takes a new tick only once its last one is queued, and the back end reads
//   the queue while the front end works on the next tick. Throughput is set by the
//   iterative CORDIC in the back end.
// A finished tick skips the CORDIC in the back end.
// Reset (rst_n low, synchronous): steer state 0, registers to defaults, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_steering_control_core #(
  parameter int ANGLE_BITS   = wsc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = wsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wsc_in_if.sink     in_ch,
  wsc_out_if.source  out_ch,
  wsc_cfg_if.sink    cfg_ch
);

  wsc_pkg::cfg_t  cfg_r;
  wsc_pkg::qent_t q_wdata, q_rdata;
  logic           q_wr, q_rd, q_full, q_empty;

  assign cfg_ch.ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reach_distance <= wsc_pkg::REACH_W'(65536);
      cfg_r.max_steer_step <= wsc_pkg::STEP_W'(364);
      cfg_r.steer_limit    <= wsc_pkg::LIMIT_W'(5461);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        wsc_pkg::CFG_REACH: cfg_r.reach_distance <= cfg_ch.data[wsc_pkg::REACH_W-1:0];
        wsc_pkg::CFG_STEP:  cfg_r.max_steer_step <= cfg_ch.data[wsc_pkg::STEP_W-1:0];
        wsc_pkg::CFG_LIMIT: cfg_r.steer_limit    <= cfg_ch.data[wsc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  wsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_wdata (q_wdata),
    .q_wr    (q_wr),
    .q_full  (q_full)
  );

  wsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  wsc_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

[hdl/wsc_front.sv]
// Front end: takes a tick, forms saturated offsets, runs the reach test, queues the aim.
`timescale 1ns / 1ps
`default_nettype none
module wsc_front (
  input  logic            clk,
  input  logic            rst_n,
  wsc_in_if.sink          in_ch,
  input  wsc_pkg::cfg_t   cfg,
  output wsc_pkg::qent_t  q_wdata,
  output logic            q_wr,
  input  logic            q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SQX  = 5'b00010,
    F_SQY  = 5'b00100,
    F_SQR  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [wsc_pkg::COORD_W-1:0] tdx_r, tdy_r, ndx_r, ndy_r;
  logic signed [wsc_pkg::ANGLE_W-1:0] hd_r;
  logic                               nexist_r;
  logic [63:0]                        prod_r, acc_r;
  logic [31:0]                        mul_a, mul_b;
  logic                               reached;
  logic                               accept;

  // Waypoint minus vehicle, clipped to signed 32 bits
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r = d[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Shared multiplier: dx^2, dy^2, then reach^2
  always_comb begin
    mul_a = mag(tdx_r);
    mul_b = mag(tdx_r);
    case (state_r)
      F_SQY: begin
        mul_a = mag(tdy_r);
        mul_b = mag(tdy_r);
      end
      F_SQR: begin
        mul_a = {1'b0, cfg.reach_distance};
        mul_b = {1'b0, cfg.reach_distance};
      end
      default: ;
    endcase
  end

  assign reached = (acc_r < prod_r);

  // Queue the aimed offset with its flags
  always_comb begin
    q_wdata.adv     = reached;
    q_wdata.fin     = reached && !nexist_r;
    q_wdata.dx      = reached ? ndx_r : tdx_r;
    q_wdata.dy      = reached ? ndy_r : tdy_r;
    q_wdata.heading = hd_r;
  end

  assign q_wr = (state_r == F_PUSH) && !q_full;

  // Sequence the front
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_SQX;
      F_SQX:   state_nxt = F_SQY;
      F_SQY:   state_nxt = F_SQR;
      F_SQR:   state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture offsets on transfer, then accumulate squares
  always_ff @(posedge clk) begin
    if (accept) begin
      tdx_r    <= sat_diff(in_ch.target_x, in_ch.vehicle_x);
      tdy_r    <= sat_diff(in_ch.target_y, in_ch.vehicle_y);
      ndx_r    <= sat_diff(in_ch.next_x, in_ch.vehicle_x);
      ndy_r    <= sat_diff(in_ch.next_y, in_ch.vehicle_y);
      hd_r     <= in_ch.vehicle_heading;
      nexist_r <= in_ch.next_exists;
    end
    case (state_r)
      F_SQX: prod_r <= mul_a * mul_b;
      F_SQY: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= prod_r;
      end
      F_SQR: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= acc_r + prod_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hdl/wsc_queue.sv]
// Short queue of classified ticks between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module wsc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  wsc_pkg::qent_t wdata,
  output logic           full,
  input  logic           rd,
  output wsc_pkg::qent_t rdata,
  output logic           empty
);

  localparam int Depth = wsc_pkg::QUEUE_DEPTH;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  wsc_pkg::qent_t    mem_r [Depth];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_wr, do_rd;

  assign full  = (cnt_r == CW'(Depth));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rd_ptr_r];

  // Store on write
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wdata;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/wsc_back.sv]
// Back end: CORDIC bearing, rate and angle limiting, steer state and result register.
`timescale 1ns / 1ps
`default_nettype none
module wsc_back #(
  parameter int ANGLE_BITS   = wsc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = wsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wsc_pkg::cfg_t  cfg,
  input  wsc_pkg::qent_t q_rdata,
  input  logic           q_empty,
  output logic           q_rd,
  wsc_out_if.source      out_ch
);

  localparam int XW   = wsc_pkg::XW;
  localparam int AW   = wsc_pkg::ANGLE_W;
  localparam int IW   = $clog2(CORDIC_STEPS);
  localparam int SH   = 32 - ANGLE_BITS;
  localparam logic [31:0] HALF = 32'(1) << (SH - 1);
  localparam int RSH  = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int LSH  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_ROT   = 4'b0010,
    B_DELTA = 4'b0100,
    B_APPLY = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic signed [XW-1:0] x_r, y_r, xs, ys, x0, y0;
  logic [31:0]          z_r;
  logic [IW-1:0]        cnt_r;
  logic signed [AW-1:0] hd_r, delta_r, steer_state_r;
  logic                 adv_r, fin_r;
  logic                 zero_vec, out_load;

  logic [31:0]          zr, q32, qb;
  logic [AW-1:0]        bearing, diff;
  logic signed [AW:0]   d17, stp17, s17, lim17, steer17;
  logic signed [AW-1:0] delta_nxt, steer_nxt;

  logic                 out_valid_r, out_adv_r, out_fin_r;
  logic signed [AW-1:0] out_steer_r;

  assign q_rd     = (state_r == B_IDLE) && !q_empty;
  assign zero_vec = (q_rdata.dx == '0) && (q_rdata.dy == '0);
  assign out_load = (state_r == B_APPLY) && (!out_valid_r || out_ch.ready);

  // Fold the left half plane onto the right by a half turn
  always_comb begin
    x0 = XW'(q_rdata.dx);
    y0 = XW'(q_rdata.dy);
    if (q_rdata.dx[wsc_pkg::COORD_W-1]) begin
      x0 = -x0;
      y0 = -y0;
    end
  end

  // Floor shifts for this iteration
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;

  // Round the turn accumulator to ANGLE_BITS and express in 16-bit units
  assign zr      = z_r + HALF;
  assign q32     = zr >> SH;
  assign qb      = (q32 >> RSH) << LSH;
  assign bearing = qb[AW-1:0];

  // Wrapped error, clamped to the step size
  always_comb begin
    diff  = bearing - hd_r - steer_state_r;
    d17   = {diff[AW-1], diff};
    stp17 = signed'({2'b00, cfg.max_steer_step});
    if (d17 > stp17) begin
      delta_nxt = stp17[AW-1:0];
    end else if (d17 < -stp17) begin
      delta_nxt = AW'(-stp17);
    end else begin
      delta_nxt = diff;
    end
  end

  // New steer, clamped to the limit
  always_comb begin
    s17   = {steer_state_r[AW-1], steer_state_r} + {delta_r[AW-1], delta_r};
    lim17 = signed'({2'b00, cfg.steer_limit});
    if (s17 > lim17) begin
      steer17 = lim17;
    end else if (s17 < -lim17) begin
      steer17 = -lim17;
    end else begin
      steer17 = s17;
    end
    steer_nxt = steer17[AW-1:0];
  end

  // Sequence the back end
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_rd) begin
          if (q_rdata.fin) state_nxt = B_APPLY;
          else if (zero_vec) state_nxt = B_DELTA;
          else state_nxt = B_ROT;
        end
      end
      B_ROT:   if (cnt_r == LAST) state_nxt = B_DELTA;
      B_DELTA: state_nxt = B_APPLY;
      B_APPLY: if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // CORDIC vectoring datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_rd) begin
          hd_r  <= q_rdata.heading;
          adv_r <= q_rdata.adv;
          fin_r <= q_rdata.fin;
          x_r   <= x0;
          y_r   <= y0;
          cnt_r <= '0;
          if (zero_vec) z_r <= '0;
          else z_r <= q_rdata.dx[wsc_pkg::COORD_W-1] ? 32'h80000000 : 32'h0;
        end
      end
      B_ROT: begin
        if (!y_r[XW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + wsc_pkg::atan_turn(5'(cnt_r));
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - wsc_pkg::atan_turn(5'(cnt_r));
        end
        cnt_r <= cnt_r + 1'b1;
      end
      B_DELTA: delta_r <= delta_nxt;
      default: ;
    endcase
  end

  // Steer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_state_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_adv_r   <= adv_r;
        out_fin_r   <= fin_r;
        if (fin_r) begin
          out_steer_r <= steer_state_r;
        end else begin
          out_steer_r   <= steer_nxt;
          steer_state_r <= steer_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.steer_angle = out_steer_r;
  assign out_ch.advanced    = out_adv_r;
  assign out_ch.finished    = out_fin_r;

  // A finished tick always reports the waypoint as reached
  a_fin_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_adv_r)
    else $error("finished result without advanced");

  // The iteration counter never runs past the last step
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROT) |-> (cnt_r <= LAST))
    else $error("CORDIC counter out of range");

  // A finished tick leaves the steer state alone
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && fin_r |=> $stable(steer_state_r))
    else $error("steer state changed on finished tick");

  // A new result is loaded only after the previous one was taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_steer_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

[tb/sv/tb_waypoint_steering_control_core.sv]
// Self-checking testbench for the waypoint steering core: directed ticks, then random ticks with and without pacing.
`timescale 1ns / 1ps
module tb_waypoint_steering_control_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int FIRST_ITEMS    = 60;
  localparam int PHASE_ITEMS    = 80;
  localparam int RESET_CYCLES   = 6;

  localparam logic [wsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [wsc_pkg::COORD_W-1:0] CMAX = 32'sh7FFFFFFF;
  localparam logic signed [wsc_pkg::COORD_W-1:0] CMIN = 32'sh80000000;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [31:0] ATAN_TURN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  typedef enum logic [1:0] {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;

  typedef struct packed {
    logic signed [wsc_pkg::COORD_W-1:0] vehicle_x;
    logic signed [wsc_pkg::COORD_W-1:0] vehicle_y;
    logic signed [wsc_pkg::ANGLE_W-1:0] vehicle_heading;
    logic signed [wsc_pkg::COORD_W-1:0] target_x;
    logic signed [wsc_pkg::COORD_W-1:0] target_y;
    logic signed [wsc_pkg::COORD_W-1:0] next_x;
    logic signed [wsc_pkg::COORD_W-1:0] next_y;
    logic                               next_exists;
  } tick_t;

  typedef struct packed {
    logic signed [wsc_pkg::ANGLE_W-1:0] steer_angle;
    logic                               advanced;
    logic                               finished;
  } steer_res_t;

  typedef struct packed {
    tick_t      t;
    logic       typed;
    steer_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] reach;
    logic [31:0] step;
    logic [31:0] limit;
    pace_t       pace;
    logic        rand_cfg;
  } phase_t;

  // Directed ticks at reset settings (reach 1 m, step 364, limit 5461)
  localparam dir_row_t DIRECTED [17] = '{
    // reached with no next waypoint straight out of reset
    '{'{0, 0, 16'sd0, 0, 0, 0, 0, 1'b0}, 1'b1, '{16'sd0, 1'b1, 1'b1}},
    // reached, next waypoint on the vehicle: zero vector
    '{'{0, 0, 16'sd0, 0, 0, 0, 0, 1'b1}, 1'b1, '{16'sd0, 1'b1, 1'b0}},
    // exact half turn wraps negative, then rate limited
    '{'{0, 0, 16'sh8000, 0, 0, 0, 0, 1'b1}, 1'b1, '{-16'sd364, 1'b1, 1'b0}},
    // finished holds the steer angle, next waypoint ignored
    '{'{0, 0, 16'sd0, 0, 0, CMAX, CMAX, 1'b0}, 1'b1, '{-16'sd364, 1'b1, 1'b1}},
    // quarter turn off, rate limited again
    '{'{0, 0, 16'sd16384, 0, 0, 0, 0, 1'b1}, 1'b1, '{-16'sd728, 1'b1, 1'b0}},
    // distance equal to reach: not reached
    '{'{0, 0, 16'sd0, 65536, 0, 0, 0, 1'b0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // just inside reach with no next waypoint
    '{'{0, 0, 16'sd0, 65535, 0, 0, 0, 1'b0}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // saturated differences, positive
    '{'{CMIN, CMIN, 16'sh7FFF, CMAX, CMAX, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // saturated differences, negative: left half plane at the most negative value
    '{'{CMAX, CMAX, 16'sh8000, CMIN, CMIN, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{0, 0, 16'sd0, 0, 655360, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{0, 0, 16'sd0, 0, -655360, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{0, 0, 16'sd0, -655360, 0, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{0, 0, 16'sd8192, -196608, -458752, 0, 0, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // not reached: next waypoint must not matter
    '{'{0, 0, 16'sd0, 1310720, 327680, CMIN, CMAX, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // reached, aim at next waypoint in the left half plane
    '{'{100, 100, -16'sd1, 100, 100, -327680, 196608, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    // reached at extreme coordinates, next difference saturates both ways
    '{'{CMIN, CMAX, 16'sd0, CMIN, CMAX, CMAX, CMIN, 1'b1}, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{'{-1, -1, 16'sh7FFF, CMAX, CMIN, -1, -1, 1'b0}, 1'b0, '{16'sd0, 1'b0, 1'b0}}
  };

  // Register settings and pacing per random phase
  localparam phase_t PHASES [8] = '{
    '{32'd0,        32'd32767,    32'd16384,    PACE_SRC,  1'b0},
    '{32'h7FFFFFFF, 32'd0,        32'd0,        PACE_SNK,  1'b0},
    '{32'h00100000, 32'd1000,     32'd32767,    PACE_BOTH, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFF80C8, 32'h00018FA0, PACE_FREE, 1'b0},
    '{32'd0,        32'd0,        32'd0,        PACE_SRC,  1'b1},
    '{32'd65536,    32'd364,      32'd5461,     PACE_SNK,  1'b0},
    '{32'd0,        32'd0,        32'd0,        PACE_BOTH, 1'b1},
    '{32'd0,        32'd0,        32'd0,        PACE_FREE, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  wsc_in_if  in_ch ();
  wsc_out_if out_ch ();
  wsc_cfg_if cfg_ch ();

  waypoint_steering_control_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the block's registers and steer state
  logic [wsc_pkg::REACH_W-1:0]        reach_q = 31'd65536;
  logic [wsc_pkg::STEP_W-1:0]         step_q  = 15'd364;
  logic [wsc_pkg::LIMIT_W-1:0]        limit_q = 15'd5461;
  logic signed [wsc_pkg::ANGLE_W-1:0] steer_q = '0;

  steer_res_t pending_steer [$];
  int         n_sent = 0;
  int         n_done = 0;
  int         mismatches = 0;
  int         quiet = 0;
  pace_t      pace = PACE_FREE;
  logic       row_typed = 1'b0;
  steer_res_t row_exp = '0;

  function automatic int pace_pct(pace_t p, logic rx);
    if (p == PACE_BOTH) return 21;
    if (rx ? (p == PACE_SNK) : (p == PACE_SRC)) return 68;
    return 0;
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    longint d;
    d = a - b;
    if (d > 64'sd2147483647) return 64'sd2147483647;
    if (d < -64'sd2147483648) return -64'sd2147483648;
    return d;
  endfunction

  // Advance the steer state by one tick and return the result it produces
  function automatic steer_res_t next_steer(tick_t t);
    longint dx, dy, cx, cy, xs, ys;
    logic [63:0] d2, r2;
    logic [31:0] z, q;
    logic [15:0] bearing;
    logic signed [15:0] wrapped;
    int delta, steer;
    steer_res_t r;
    dx = sat_diff(t.target_x, t.vehicle_x);
    dy = sat_diff(t.target_y, t.vehicle_y);
    d2 = 64'(dx * dx) + 64'(dy * dy);
    r2 = 64'(reach_q) * 64'(reach_q);
    r.advanced = (d2 < r2);
    r.finished = 1'b0;
    if (r.advanced) begin
      if (!t.next_exists) begin
        r.finished = 1'b1;
        r.steer_angle = steer_q;
        return r;
      end
      dx = sat_diff(t.next_x, t.vehicle_x);
      dy = sat_diff(t.next_y, t.vehicle_y);
    end
    // Vectoring CORDIC; a zero vector has bearing zero
    bearing = '0;
    if (dx != 0 || dy != 0) begin
      cx = dx;
      cy = dy;
      z = '0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z = 32'h80000000;
      end
      for (int i = 0; i < wsc_pkg::CORDIC_STEPS_DEF && i < 24; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx = cx + ys;
          cy = cy - xs;
          z = z + ATAN_TURN[i];
        end else begin
          cx = cx - ys;
          cy = cy + xs;
          z = z - ATAN_TURN[i];
        end
      end
      // Round to nearest at 16 bits of a turn
      q = (z + 32'h00008000) >> 16;
      bearing = q[15:0];
    end
    wrapped = bearing - t.vehicle_heading - steer_q;
    delta = wrapped;
    if (delta > int'(step_q)) delta = int'(step_q);
    else if (delta < -int'(step_q)) delta = -int'(step_q);
    steer = int'(steer_q) + delta;
    if (steer > int'(limit_q)) steer = int'(limit_q);
    else if (steer < -int'(limit_q)) steer = -int'(limit_q);
    steer_q = 16'(steer);
    r.steer_angle = steer_q;
    return r;
  endfunction

  function automatic longint spread(longint m);
    logic [63:0] r;
    if (m <= 0) return 0;
    r = {$urandom, $urandom};
    return longint'(r % 64'(2 * m + 1)) - m;
  endfunction

  function automatic logic signed [31:0] nudge(longint base, longint off);
    return 32'(sat_diff(base, -off));
  endfunction

  function automatic logic signed [31:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return nudge(0, spread(64'sd1 << 24));
    if (sel < 8) return $urandom;
    case ($urandom_range(0, 3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Random tick, mostly placed around the reach circle so waypoints get reached
  function automatic tick_t random_tick(longint reach);
    tick_t t;
    int sel;
    longint off;
    t.vehicle_x = pick_coord();
    t.vehicle_y = pick_coord();
    t.vehicle_heading = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      t.target_x = nudge(t.vehicle_x, spread(reach * 3 / 4));
      t.target_y = nudge(t.vehicle_y, spread(reach * 3 / 4));
    end else if (sel < 55) begin
      // right on the reach boundary or one step inside
      off = reach - longint'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) off = -off;
      if ($urandom_range(0, 1) != 0) begin
        t.target_x = nudge(t.vehicle_x, off);
        t.target_y = t.vehicle_y;
      end else begin
        t.target_x = t.vehicle_x;
        t.target_y = nudge(t.vehicle_y, off);
      end
    end else if (sel < 85) begin
      t.target_x = nudge(t.vehicle_x, spread(64'sd1 << 22));
      t.target_y = nudge(t.vehicle_y, spread(64'sd1 << 22));
    end else begin
      t.target_x = $urandom;
      t.target_y = $urandom;
    end
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      t.next_x = nudge(t.vehicle_x, spread(64'sd1 << 22));
      t.next_y = nudge(t.vehicle_y, spread(64'sd1 << 22));
    end else if (sel < 80) begin
      t.next_x = $urandom;
      t.next_y = $urandom;
    end else begin
      t.next_x = t.vehicle_x;
      t.next_y = t.vehicle_y;
    end
    t.next_exists = ($urandom_range(0, 99) < 70);
    return t;
  endfunction

  // Present one tick after an optional idle gap and hold it until the transfer
  task automatic send_tick(input tick_t t, input logic typed, input steer_res_t ex,
                           input int tx_pct);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.vehicle_x       <= t.vehicle_x;
    in_ch.vehicle_y       <= t.vehicle_y;
    in_ch.vehicle_heading <= t.vehicle_heading;
    in_ch.target_x        <= t.target_x;
    in_ch.target_y        <= t.target_y;
    in_ch.next_x          <= t.next_x;
    in_ch.next_y          <= t.next_y;
    in_ch.next_exists     <= t.next_exists;
    row_typed             <= typed;
    row_exp               <= ex;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    n_sent++;
  endtask

  // Drop valid and wait until every result has been checked
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_done < n_sent);
  endtask

  // Hold a register write until its transfer; the caller drops valid afterwards
  task automatic write_reg(input logic [wsc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  // Result channel backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= pace_pct(pace, 1'b1));
  end

  // Predict on every input transfer, check every result transfer
  always @(posedge clk) begin : scoreboard
    tick_t      t;
    steer_res_t want;
    steer_res_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          wsc_pkg::CFG_REACH: reach_q = cfg_ch.data[wsc_pkg::REACH_W-1:0];
          wsc_pkg::CFG_STEP:  step_q  = cfg_ch.data[wsc_pkg::STEP_W-1:0];
          wsc_pkg::CFG_LIMIT: limit_q = cfg_ch.data[wsc_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        t = '{in_ch.vehicle_x, in_ch.vehicle_y, in_ch.vehicle_heading, in_ch.target_x,
              in_ch.target_y, in_ch.next_x, in_ch.next_y, in_ch.next_exists};
        want = next_steer(t);
        pending_steer.push_back(row_typed ? row_exp : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.steer_angle, out_ch.advanced, out_ch.finished};
        if (pending_steer.size() == 0) begin
          $error("result with no tick waiting: steer_angle %0d advanced %0b finished %0b",
                 got.steer_angle, got.advanced, got.finished);
          mismatches++;
        end else begin
          want = pending_steer.pop_front();
          if (got.steer_angle !== want.steer_angle) begin
            $error("steer_angle: expected %0d, got %0d", want.steer_angle, got.steer_angle);
            mismatches++;
          end
          if (got.advanced !== want.advanced) begin
            $error("advanced: expected %0b, got %0b", want.advanced, got.advanced);
            mismatches++;
          end
          if (got.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, got.finished);
            mismatches++;
          end
          n_done <= n_done + 1;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    phase_t ph;
    longint aim_reach;
    int     tx_pct;
    // Known values on every input from time zero
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.vehicle_x       = '0;
    in_ch.vehicle_y       = '0;
    in_ch.vehicle_heading = '0;
    in_ch.target_x        = '0;
    in_ch.target_y        = '0;
    in_ch.next_x          = '0;
    in_ch.next_y          = '0;
    in_ch.next_exists     = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    out_ch.ready          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks, then random ones, at reset settings with no idling
    aim_reach = 65536;
    tx_pct = 0;
    foreach (DIRECTED[k]) begin
      send_tick(DIRECTED[k].t, DIRECTED[k].typed, DIRECTED[k].res, tx_pct);
    end
    repeat (FIRST_ITEMS) send_tick(random_tick(aim_reach), 1'b0, '0, tx_pct);

    // Reprogram while idle, then run a random phase with its own pacing
    foreach (PHASES[p]) begin
      drain();
      ph = PHASES[p];
      if (ph.rand_cfg) begin
        ph.reach = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h01000000);
        ph.step  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        ph.limit = $urandom_range(0, 16384);
      end
      write_reg(wsc_pkg::CFG_REACH, ph.reach);
      write_reg(wsc_pkg::CFG_STEP, ph.step);
      write_reg(wsc_pkg::CFG_LIMIT, ph.limit);
      write_reg(CFG_UNUSED, $urandom);
      cfg_ch.valid <= 1'b0;
      aim_reach = longint'(ph.reach[wsc_pkg::REACH_W-1:0]);
      pace <= ph.pace;
      tx_pct = pace_pct(ph.pace, 1'b0);
      repeat (PHASE_ITEMS) send_tick(random_tick(aim_reach), 1'b0, '0, tx_pct);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_steer.size() != 0) begin
      $error("%0d expected results never arrived", pending_steer.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wsc_pkg.sv
hdl/wsc_ifs.sv
hdl/wsc_front.sv
hdl/wsc_queue.sv
hdl/wsc_back.sv
hdl/waypoint_steering_control_core.sv
tb/sv/tb_waypoint_steering_control_core.sv
